>>> sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the word formats of both channels, the operation and status codes and the cell controls.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_LIST_FWD   = 3'd5,
        OP_LIST_BWD   = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  item_value;
        logic [COUNT_W-1:0]  item_count;
        logic                last;
    } t_out_word;

    // One-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_r;    // push front: every word moves one cell back
        logic append;     // the cell just past the back takes the new word
        logic shift_l;    // pop front: every word moves one cell forward
        logic rot_l;      // forward listing step: rotate the occupied cells forward
        logic rot_r;      // backward listing step: rotate the occupied cells backward
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> sv/deq_cell.sv
// One storage cell of the queue chain; takes a neighbor, input, head or tail word as commanded.
// Depends on deq_pkg for the cell command struct.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire                      i_clk,
    input  deq_pkg::t_cell_ctrl      i_ctrl,
    input  wire  [CW-1:0]            i_count,
    input  wire  [DATA_WIDTH-1:0]    i_value,
    input  wire  [DATA_WIDTH-1:0]    i_left,
    input  wire  [DATA_WIDTH-1:0]    i_right,
    input  wire  [DATA_WIDTH-1:0]    i_head,
    input  wire  [DATA_WIDTH-1:0]    i_tail,
    output logic [DATA_WIDTH-1:0]    o_data
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [CW-1:0]         w_last_idx;

    assign w_last_idx = i_count - CW'(1);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift_r) begin
            n_data = (IDX == 0) ? i_value : i_left;
        end else if (i_ctrl.append) begin
            if (MY_IDX == i_count) begin
                n_data = i_value;
            end
        end else if (i_ctrl.shift_l) begin
            n_data = i_right;
        end else if (i_ctrl.rot_l) begin
            // The back of the occupied run wraps around to the front word.
            if (MY_IDX == w_last_idx) begin
                n_data = i_head;
            end else if (MY_IDX < w_last_idx) begin
                n_data = i_right;
            end
        end else if (i_ctrl.rot_r) begin
            if (IDX == 0) begin
                n_data = i_tail;
            end else if (MY_IDX < i_count) begin
                n_data = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> sv/deq_ctrl.sv
// Sequencer of the queue: occupancy count, listing walk and the registered output word.
// Depends on deq_pkg for word formats, codes and the cell command struct.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  deq_pkg::t_in_word        i_in_word,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output deq_pkg::t_out_word       o_out_word,
    input  wire  [DATA_WIDTH-1:0]    i_head,
    input  wire  [DATA_WIDTH-1:0]    i_tail,
    output deq_pkg::t_cell_ctrl      o_ctrl,
    output logic [CW-1:0]            o_count
);

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_dir_bwd, n_dir_bwd;
    logic                r_out_valid, n_out_valid;
    deq_pkg::t_out_word  r_out, n_out;

    logic                w_slot_free;
    logic                w_take;
    logic                w_full;
    logic                w_empty;
    logic                w_list_last;
    logic [DATA_WIDTH-1:0] w_list_data;

    // The output register is free when empty or being emptied this cycle.
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_slot_free;
    assign w_take      = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_list_last = (r_idx == r_count - CW'(1));
    assign w_list_data = r_dir_bwd ? i_tail : i_head;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_dir_bwd   = r_dir_bwd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_ctrl      = '0;

        if (w_take) begin
            n_out.item_value = '0;
            n_out.last       = 1'b1;
            case (deq_pkg::t_op'(i_in_word.op))
                deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
                    n_out_valid = 1'b1;
                    if (w_full) begin
                        n_out.status     = deq_pkg::STATUS_FULL;
                        n_out.item_count = deq_pkg::COUNT_W'(r_count);
                    end else begin
                        if (deq_pkg::t_op'(i_in_word.op) == deq_pkg::OP_PUSH_BACK) begin
                            o_ctrl.append = 1'b1;
                        end else begin
                            o_ctrl.shift_r = 1'b1;
                        end
                        n_count          = r_count + CW'(1);
                        n_out.status     = deq_pkg::STATUS_OK;
                        n_out.item_count = deq_pkg::COUNT_W'(r_count + CW'(1));
                    end
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                    n_out_valid = 1'b1;
                    if (w_empty) begin
                        n_out.status     = deq_pkg::STATUS_EMPTY;
                        n_out.item_count = '0;
                    end else begin
                        // Popping the back only shrinks the count; the word is left behind.
                        o_ctrl.shift_l   = (deq_pkg::t_op'(i_in_word.op)
                                            == deq_pkg::OP_POP_FRONT);
                        n_count          = r_count - CW'(1);
                        n_out.status     = deq_pkg::STATUS_OK;
                        n_out.item_count = deq_pkg::COUNT_W'(r_count - CW'(1));
                    end
                end
                deq_pkg::OP_CLEAR: begin
                    n_out_valid      = 1'b1;
                    n_count          = '0;
                    n_out.status     = deq_pkg::STATUS_OK;
                    n_out.item_count = '0;
                end
                deq_pkg::OP_LIST_FWD, deq_pkg::OP_LIST_BWD: begin
                    if (w_empty) begin
                        n_out_valid      = 1'b1;
                        n_out.status     = deq_pkg::STATUS_EMPTY;
                        n_out.item_count = '0;
                    end else begin
                        n_state   = ST_LIST;
                        n_idx     = '0;
                        n_dir_bwd = (deq_pkg::t_op'(i_in_word.op) == deq_pkg::OP_LIST_BWD);
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == ST_LIST && w_slot_free) begin
            // Each step emits the word at the walking end and rotates the run by one,
            // so after count steps the cells are back in their original order.
            n_out_valid      = 1'b1;
            n_out.status     = deq_pkg::STATUS_OK;
            n_out.item_value = deq_pkg::VALUE_W'(w_list_data);
            n_out.item_count = deq_pkg::COUNT_W'(r_count);
            n_out.last       = w_list_last;
            o_ctrl.rot_l     = !r_dir_bwd;
            o_ctrl.rot_r     = r_dir_bwd;
            n_idx            = r_idx + CW'(1);
            if (w_list_last) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_dir_bwd <= n_dir_bwd;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_count     = r_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy count exceeds depth");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |-> (r_count != '0))
        else $error("listing walk on an empty queue");

    a_list_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |=> (r_count == $past(r_count)))
        else $error("count changed during a listing");

    a_list_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |-> !o_in_ready)
        else $error("input accepted during a listing");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == deq_pkg::STATUS_FULL)
        |-> (r_out.item_count == deq_pkg::COUNT_W'(DEPTH)))
        else $error("full status with a count other than depth");
`endif

endmodule

`default_nettype wire

>>> sv/double_ended_queue_top.sv
// Top level of the double-ended queue: a chain of storage cells driven by one sequencer.
// Depends on deq_pkg, deq_cell and deq_ctrl.
//
//  Channel  Signals                                   Dir  Word
//  input    i_in_valid, o_in_ready, i_in_word         in   op, value
//  output   o_out_valid, i_out_ready, o_out_word      out  status, item_value, item_count, last
//
// One word may be accepted every cycle while the output is not stalled and no listing runs.
// A listing of N stored words starts the walk, then gives one word per cycle unless the output
// stalls, one rotation step of the cell chain per word; input is held off until the last one.
// Reset (i_rst_n low, synchronous) empties the queue; cell contents are not cleared.
// A stalled output holds its word and blocks new input and further listing steps.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  deq_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output deq_pkg::t_out_word  o_out_word
);

    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::t_cell_ctrl    w_ctrl;
    logic [CW-1:0]          w_count;
    logic [CW-1:0]          w_last_idx;
    logic [DATA_WIDTH-1:0]  w_value;
    logic [DATA_WIDTH-1:0]  w_data [DEPTH];
    logic [DATA_WIDTH-1:0]  w_tail;

    assign w_value    = DATA_WIDTH'(i_in_word.value);
    assign w_last_idx = w_count - CW'(1);

    // Back word of the occupied run.
    always_comb begin
        w_tail = w_data[0];
        for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) == w_last_idx) begin
                w_tail = w_data[i];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        deq_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_count (w_count),
            .i_value (w_value),
            .i_left  (w_data[(g == 0) ? 0 : g - 1]),
            .i_right (w_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_head  (w_data[0]),
            .i_tail  (w_tail),
            .o_data  (w_data[g])
        );
    end

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_head      (w_data[0]),
        .i_tail      (w_tail),
        .o_ctrl      (w_ctrl),
        .o_count     (w_count)
    );

endmodule

`default_nettype wire
